// File: sv/csvt_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and control structs for the csv field tokenizer
// no dependencies; imported by the tokenizer unit, the controller and the datapath
package csvt_pkg;

    localparam int WS_HOLD_DEPTH_DEF = 16;

    localparam int BYTE_W = 8;
    localparam int SLOT_W = 3;

    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    localparam logic [SLOT_W-1:0] SLOT_CATEGORY = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_FIRST    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_EXTRA    = 3'd7;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_UNQ,
        PH_QUO,
        PH_QUO_Q,
        PH_TERM,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        TK_CONTENT,
        TK_FIELD,
        TK_RECORD,
        TK_DATA,
        TK_ERROR
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_QUOTE,
        ERR_END,
        ERR_WS_OVF
    } err_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_RD,
        ST_RUN_OUT,
        ST_CHAR,
        ST_STRUCT,
        ST_TAIL
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_RUN,
        SEL_CHAR,
        SEL_STRUCT,
        SEL_TAIL
    } out_sel_t;

    // which result groups one byte produces, in emission order
    typedef struct packed {
        logic run;
        logic chr;
        logic strc;
        logic tail;
    } plan_flags_t;

    typedef struct packed {
        plan_flags_t now;
        plan_flags_t held;
        logic        run_last;
        logic        out_free;
    } dp_status_t;

    typedef struct packed {
        logic     accept;
        logic     ram_rd;
        logic     load_out;
        out_sel_t sel;
    } dp_cmd_t;

endpackage

// File: sv/csv_field_tokenizer_unit.sv
`timescale 1ns / 1ps
// streaming csv tokenizer: one byte of text per input transaction, a flag on the final
// byte; each byte yields zero or more tokens (content bytes tagged with their record slot,
// field end, record end, data end, error), the last one of a byte marked by last_of_run.
// a byte that yields no token is simply taken; otherwise the byte is taken first and
// each token then passes through the output register in turn. trailing whitespace of
// an unquoted field is parked in a small ram and replayed when a later content byte
// shows it was interior; each replayed byte is first read from the ram, whose read is
// registered, and then loaded. a new byte is taken only after the final token of the
// previous one sits in the output register. the whitespace ram needs no clearing after
// reset. depends on csvt_pkg, csvt_ctrl and csvt_datapath.
module csv_field_tokenizer_unit #(
    parameter int WS_HOLD_DEPTH = csvt_pkg::WS_HOLD_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    // token output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] token_kind,
    output logic [7:0] char_value,
    output logic [2:0] slot_index,
    output logic [1:0] error_code,
    output logic       last_of_run
);

    import csvt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller: takes a byte, then steps through run, char, structure and tail tokens
    csvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // datapath: parser state, whitespace buffer, token output register
    csvt_datapath #(
        .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .token_kind  (token_kind),
        .char_value  (char_value),
        .slot_index  (slot_index),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    // a byte that produced tokens keeps the input closed until they are all issued
    a_busy_after_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (status.now != '0)) |=> in_stall)
        else $error("input taken while tokens of the previous byte pending");

    // error code is set exactly on error tokens
    a_code_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((error_code != ERR_NONE) == (token_kind == TK_ERROR)))
        else $error("error code and token kind disagree");

    // only content tokens carry a character
    a_char_on_content: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (token_kind != TK_CONTENT)) |-> (char_value == '0))
        else $error("character on a non-content token");

    // data end and error tokens always close a byte's run
    a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((token_kind == TK_DATA) || (token_kind == TK_ERROR)))
        |-> last_of_run)
        else $error("data end or error token not marked last");

endmodule

// File: sv/csvt_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module csvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/csvt_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller: accepts a byte, then walks the result groups it produced
// depends on csvt_pkg
module csvt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  csvt_pkg::dp_status_t status,
    output logic                in_stall,
    output csvt_pkg::dp_cmd_t    cmd
);

    import csvt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    function automatic ctrl_state_t first_state(input plan_flags_t f);
        ctrl_state_t s;
        if (f.run)
            s = ST_RUN_RD;
        else if (f.chr)
            s = ST_CHAR;
        else if (f.strc)
            s = ST_STRUCT;
        else if (f.tail)
            s = ST_TAIL;
        else
            s = ST_IDLE;
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.ram_rd   = 1'b0;
        cmd.load_out = 1'b0;
        cmd.sel      = SEL_RUN;
        in_stall     = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = first_state(status.now);
                end
            end
            ST_RUN_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = ST_RUN_OUT;
            end
            ST_RUN_OUT:
            begin
                cmd.sel = SEL_RUN;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    // a released run is always followed by the byte that released it
                    state_next   = status.run_last ? ST_CHAR : ST_RUN_RD;
                end
            end
            ST_CHAR:
            begin
                cmd.sel = SEL_CHAR;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = first_state('{run: 1'b0, chr: 1'b0,
                                                 strc: status.held.strc,
                                                 tail: status.held.tail});
                end
            end
            ST_STRUCT:
            begin
                cmd.sel = SEL_STRUCT;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = status.held.tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                cmd.sel = SEL_TAIL;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/csvt_datapath.sv
`timescale 1ns / 1ps
// parser state, per-byte decision logic, held whitespace buffer and output register
// depends on csvt_pkg and csvt_ram
module csvt_datapath #(
    parameter int WS_HOLD_DEPTH = csvt_pkg::WS_HOLD_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csvt_pkg::dp_cmd_t    cmd,
    output csvt_pkg::dp_status_t status,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [2:0]          token_kind,
    output logic [7:0]          char_value,
    output logic [2:0]          slot_index,
    output logic [1:0]          error_code,
    output logic                last_of_run
);

    import csvt_pkg::*;

    localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);
    localparam int AW    = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;

    // parser state
    phase_t            phase_reg, phase_next;
    logic              in_record_reg, in_record_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;

    // plan of the byte being emitted
    plan_flags_t       plan_reg;
    logic [CNT_W-1:0]  run_cnt_reg;
    logic [CNT_W-1:0]  run_idx_reg;
    logic [BYTE_W-1:0] char_reg;
    tok_kind_t         struct_kind_reg;
    tok_kind_t         tail_kind_reg;
    err_code_t         tail_code_reg;
    logic [SLOT_W-1:0] slot_cur_reg;
    logic [SLOT_W-1:0] slot_tail_reg;

    // output register
    logic              out_valid_reg;
    tok_kind_t         tok_kind_reg;
    logic [BYTE_W-1:0] out_char_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    err_code_t         out_code_reg;
    logic              out_last_reg;

    // decision
    plan_flags_t       plan_now;
    logic              do_field, do_record, do_clear, halted, ws_we;
    err_code_t         err;
    tok_kind_t         tail_kind;
    logic [SLOT_W-1:0] tail_slot;
    logic              is_ws, is_nl, is_comma, is_quote, ws_full;
    logic [BYTE_W-1:0] ram_rdata;
    logic              out_free;

    assign is_ws    = byte_value inside {CH_SPACE, CH_TAB};
    assign is_nl    = byte_value inside {CH_CR, CH_LF};
    assign is_comma = (byte_value == CH_COMMA);
    assign is_quote = (byte_value == CH_QUOTE);
    assign ws_full  = ((CNT_W+1)'(held_count_reg) + (CNT_W+1)'(1))
                      >= (CNT_W+1)'(WS_HOLD_DEPTH);

    always_comb
    begin
        phase_next      = phase_reg;
        in_record_next  = in_record_reg;
        slot_next       = slot_reg;
        nonempty_next   = nonempty_reg;
        held_count_next = held_count_reg;
        plan_now        = '0;
        do_field        = 1'b0;
        do_record       = 1'b0;
        do_clear        = 1'b0;
        halted          = 1'b0;
        ws_we           = 1'b0;
        err             = ERR_NONE;
        tail_kind       = TK_DATA;
        case (phase_reg)
            PH_HALT:
            begin
                halted = 1'b1;
            end
            PH_UNQ:
            begin
                if (is_quote)
                    err = ERR_QUOTE;
                else if (is_nl)
                    do_record = 1'b1;
                else if (is_comma)
                    do_field = 1'b1;
                else if (is_ws)
                begin
                    // whitespace on the last byte is trailing and simply dropped
                    if (!last_byte)
                    begin
                        if (ws_full)
                            err = ERR_WS_OVF;
                        else
                        begin
                            ws_we           = 1'b1;
                            held_count_next = held_count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    plan_now.run    = (held_count_reg != '0);
                    plan_now.chr    = 1'b1;
                    held_count_next = '0;
                end
            end
            PH_QUO:
            begin
                if (is_quote)
                    phase_next = PH_QUO_Q;
                else
                begin
                    plan_now.chr  = 1'b1;
                    nonempty_next = 1'b1;
                    if (last_byte)
                        err = ERR_END;
                end
            end
            PH_QUO_Q:
            begin
                if (is_quote)
                begin
                    // doubled quote is an escaped quote character
                    plan_now.chr  = 1'b1;
                    nonempty_next = 1'b1;
                    phase_next    = PH_QUO;
                    if (last_byte)
                        err = ERR_END;
                end
                else
                begin
                    phase_next = PH_TERM;
                    if (is_nl)
                        do_record = 1'b1;
                    else if (is_comma)
                        do_field = 1'b1;
                end
            end
            PH_TERM:
            begin
                if (is_nl)
                    do_record = 1'b1;
                else if (is_comma)
                    do_field = 1'b1;
            end
            PH_SEEK:
            begin
                if (is_ws)
                begin
                    // leading whitespace
                end
                else if (is_nl)
                begin
                    if (in_record_reg)
                        do_record = 1'b1;
                end
                else if (is_comma)
                    do_field = 1'b1;
                else if (is_quote)
                begin
                    phase_next = PH_QUO;
                    if (last_byte)
                        err = ERR_END;
                end
                else
                begin
                    plan_now.chr  = 1'b1;
                    nonempty_next = 1'b1;
                    phase_next    = PH_UNQ;
                end
            end
            default:
            begin
            end
        endcase

        if (do_field)
        begin
            plan_now.strc = 1'b1;
            if (slot_reg == SLOT_CATEGORY)
            begin
                if (!nonempty_reg)
                    slot_next = SLOT_FIRST;
            end
            else if (slot_reg != SLOT_EXTRA)
                slot_next = slot_reg + SLOT_W'(1);
            in_record_next  = 1'b1;
            nonempty_next   = 1'b0;
            held_count_next = '0;
            phase_next      = PH_SEEK;
        end
        if (do_record)
        begin
            plan_now.strc   = 1'b1;
            in_record_next  = 1'b0;
            slot_next       = SLOT_CATEGORY;
            nonempty_next   = 1'b0;
            held_count_next = '0;
            phase_next      = PH_SEEK;
        end

        tail_slot = slot_next;
        if (halted)
            do_clear = last_byte;
        else if (err != ERR_NONE)
        begin
            plan_now.tail   = 1'b1;
            tail_kind       = TK_ERROR;
            held_count_next = '0;
            if (last_byte)
                do_clear = 1'b1;
            else
                phase_next = PH_HALT;
        end
        else if (last_byte)
        begin
            plan_now.tail = 1'b1;
            do_clear      = 1'b1;
        end

        if (do_clear)
        begin
            phase_next      = PH_SEEK;
            in_record_next  = 1'b0;
            slot_next       = SLOT_CATEGORY;
            nonempty_next   = 1'b0;
            held_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK;
            in_record_reg  <= 1'b0;
            slot_reg       <= SLOT_CATEGORY;
            nonempty_reg   <= 1'b0;
            held_count_reg <= '0;
            plan_reg       <= '0;
            run_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg      <= phase_next;
                in_record_reg  <= in_record_next;
                slot_reg       <= slot_next;
                nonempty_reg   <= nonempty_next;
                held_count_reg <= held_count_next;
                plan_reg       <= plan_now;
                run_idx_reg    <= '0;
            end
            else if (cmd.load_out && cmd.sel == SEL_RUN)
            begin
                run_idx_reg <= run_idx_reg + CNT_W'(1);
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // plan payload, loaded with the byte
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            run_cnt_reg     <= held_count_reg;
            char_reg        <= byte_value;
            struct_kind_reg <= do_field ? TK_FIELD : TK_RECORD;
            tail_kind_reg   <= tail_kind;
            tail_code_reg   <= err;
            slot_cur_reg    <= slot_reg;
            slot_tail_reg   <= tail_slot;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.sel)
                SEL_RUN:
                begin
                    tok_kind_reg <= TK_CONTENT;
                    out_char_reg <= ram_rdata;
                    out_slot_reg <= slot_cur_reg;
                    out_code_reg <= ERR_NONE;
                    out_last_reg <= 1'b0;
                end
                SEL_CHAR:
                begin
                    tok_kind_reg <= TK_CONTENT;
                    out_char_reg <= char_reg;
                    out_slot_reg <= slot_cur_reg;
                    out_code_reg <= ERR_NONE;
                    out_last_reg <= !plan_reg.strc && !plan_reg.tail;
                end
                SEL_STRUCT:
                begin
                    tok_kind_reg <= struct_kind_reg;
                    out_char_reg <= '0;
                    out_slot_reg <= slot_cur_reg;
                    out_code_reg <= ERR_NONE;
                    out_last_reg <= !plan_reg.tail;
                end
                SEL_TAIL:
                begin
                    tok_kind_reg <= tail_kind_reg;
                    out_char_reg <= '0;
                    out_slot_reg <= slot_tail_reg;
                    out_code_reg <= tail_code_reg;
                    out_last_reg <= 1'b1;
                end
                default:
                begin
                    tok_kind_reg <= TK_CONTENT;
                    out_char_reg <= '0;
                    out_slot_reg <= slot_cur_reg;
                    out_code_reg <= ERR_NONE;
                    out_last_reg <= 1'b0;
                end
            endcase
        end
    end

    csvt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WS_HOLD_DEPTH)
    ) u_ws_ram (
        .clk   (clk),
        .we    (cmd.accept && ws_we),
        .waddr (held_count_reg[AW-1:0]),
        .wdata (byte_value),
        .re    (cmd.ram_rd),
        .raddr (run_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    assign status.now      = plan_now;
    assign status.held     = plan_reg;
    assign status.run_last = ((run_idx_reg + CNT_W'(1)) == run_cnt_reg);
    assign status.out_free = out_free;

    assign out_valid   = out_valid_reg;
    assign token_kind  = tok_kind_reg;
    assign char_value  = out_char_reg;
    assign slot_index  = out_slot_reg;
    assign error_code  = out_code_reg;
    assign last_of_run = out_last_reg;

endmodule
